### hw/rtl/wbt_pkg.sv
// Package for the windowed busy-time tracker.
// Holds the payload structs, register indexes, ALU op codes and sizing constants.
// No dependencies.
package wbt_pkg;

  localparam int TIME_W      = 48;
  localparam int CNT32_W     = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_BUCKETS_DEF = 4;

  localparam logic [CNT32_W-1:0] WINDOW_RESET = 32'd100000;
  localparam logic [CNT32_W-1:0] BUCKET_RESET = 32'd50000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET = 1'b1;

  // Shared ALU op codes
  localparam logic ALU_SUBF   = 1'b0;  // a - b, floored at zero; lt = (a < b)
  localparam logic ALU_SATADD = 1'b1;  // 32-bit saturating add

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now_time;
    logic              busy_flag;
  } wbt_in_t;

  typedef struct packed {
    logic [CNT32_W-1:0] window_total;
    logic [CNT32_W-1:0] window_busy;
  } wbt_out_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;
    logic              lt;
  } wbt_alu_res_t;

endpackage

### hw/rtl/windowed_busy_time_tracker_unit.sv
// Top level of the windowed busy-time tracker.
// Sequencer, bucket store (circular buffer) and result register; uses wbt_alu.
// Depends on wbt_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): one event per transaction, either a
//   busy-flag update (func = 0) or a query (func = 1), stamped with now_time.
//   Output channel (out_valid/out_ready/out_data): one transaction per event with
//   the saturating total and busy time summed over the kept buckets.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_wdata): index 0 writes
//   window_ticks, index 1 writes bucket_ticks; always ready, write only when idle.
// Sequence: one event walks a shared subtract/add unit under a sequencer: gap, clamp,
//   start, then (on a non-empty store) age and merge test, a merge or a new bucket,
//   expiry of old buckets and a sum over the kept buckets, before the result is loaded.
//   in_ready is high only while the sequencer is idle, so a new event is taken only
//   after the result of the last one is loaded.
// Reset: rst_n (synchronous, active low) empties the store, zeroes the last event
//   time and busy flag, and restores the register reset values. No clearing pass.
// Stall: a result waiting on out_ready does not block the next event; a second
//   result holds in the final step until the output register frees up.
module windowed_busy_time_tracker_unit #(
  parameter int MAX_BUCKETS = wbt_pkg::MAX_BUCKETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wbt_pkg::wbt_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wbt_pkg::wbt_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wbt_pkg::CNT32_W-1:0]   cfg_wdata
);
  import wbt_pkg::*;

  localparam int IDX_W = $clog2(MAX_BUCKETS);
  localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BUCKETS);

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_GAP      = 4'd1;
  localparam logic [3:0] S_CLAMP    = 4'd2;
  localparam logic [3:0] S_START    = 4'd3;
  localparam logic [3:0] S_AGE      = 4'd4;
  localparam logic [3:0] S_MERGE    = 4'd5;
  localparam logic [3:0] S_MTOT     = 4'd6;
  localparam logic [3:0] S_MBUSY    = 4'd7;
  localparam logic [3:0] S_OPEN     = 4'd8;
  localparam logic [3:0] S_EXP_AGE  = 4'd9;
  localparam logic [3:0] S_EXP_CMP  = 4'd10;
  localparam logic [3:0] S_SUM_TOT  = 4'd11;
  localparam logic [3:0] S_SUM_BUSY = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  // Wrap a pointer sum (below twice the depth) into the store
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] s);
    logic [IDX_W:0] m;
    m = (s >= (IDX_W+1)'(MAX_BUCKETS)) ? s - (IDX_W+1)'(MAX_BUCKETS) : s;
    return m[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] p);
    return wrap_idx({1'b0, p} + (IDX_W+1)'(1));
  endfunction

  // Bucket store, no reset (entries are read only below the fill count)
  logic [TIME_W-1:0]  bend_r  [MAX_BUCKETS];
  logic [CNT32_W-1:0] btot_r  [MAX_BUCKETS];
  logic [CNT32_W-1:0] bbusy_r [MAX_BUCKETS];

  logic [3:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TIME_W-1:0]  last_r, last_nxt;
  logic               engine_busy_r, engine_busy_nxt;
  logic [CNT32_W-1:0] window_r, bucket_r;
  wbt_in_t            item_r;
  logic [TIME_W-1:0]  t_r, t_nxt;
  logic [CNT32_W-1:0] gap_r, gap_nxt;
  logic [CNT32_W-1:0] gbusy_r, gbusy_nxt;
  logic [CNT32_W-1:0] sum_tot_r, sum_tot_nxt;
  logic [CNT32_W-1:0] sum_busy_r, sum_busy_nxt;
  logic [IDX_W-1:0]   sp_r, sp_nxt;
  logic [CNT_W-1:0]   sn_r, sn_nxt;
  logic               out_valid_r, out_valid_nxt;
  wbt_out_t           out_data_r, out_data_nxt;

  logic [IDX_W-1:0]   newest_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [TIME_W-1:0]  rd_end;
  logic [CNT32_W-1:0] rd_tot, rd_busy;
  logic               alu_op;
  logic [TIME_W-1:0]  alu_a, alu_b;
  wbt_alu_res_t       alu_res;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr_end, wr_tot, wr_busy;
  logic [TIME_W-1:0]  wr_end_val;
  logic [CNT32_W-1:0] wr_tot_val, wr_busy_val;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign newest_idx = wrap_idx({1'b0, head_r} + (IDX_W+1)'(count_r) - (IDX_W+1)'(1));

  // Read port select
  always_comb begin
    unique case (state_r)
      S_START, S_MTOT, S_MBUSY: rd_idx = newest_idx;
      S_SUM_TOT, S_SUM_BUSY:    rd_idx = sp_r;
      default:                  rd_idx = head_r;
    endcase
  end

  assign rd_end  = bend_r[rd_idx];
  assign rd_tot  = btot_r[rd_idx];
  assign rd_busy = bbusy_r[rd_idx];

  // Operand select for the shared unit
  always_comb begin
    alu_op = ALU_SUBF;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_r)
      S_GAP: begin
        alu_a = item_r.now_time;
        alu_b = last_r;
      end
      S_CLAMP, S_EXP_CMP: begin
        alu_a = {{(TIME_W-CNT32_W){1'b0}}, window_r};
        alu_b = t_r;
      end
      S_START: begin
        alu_a = rd_end;
        alu_b = {{(TIME_W-CNT32_W){1'b0}}, rd_tot};
      end
      S_AGE: begin
        alu_a = item_r.now_time;
        alu_b = t_r;
      end
      S_MERGE: begin
        alu_a = t_r;
        alu_b = {{(TIME_W-CNT32_W){1'b0}}, bucket_r};
      end
      S_MTOT: begin
        alu_op = ALU_SATADD;
        alu_a  = {{(TIME_W-CNT32_W){1'b0}}, rd_tot};
        alu_b  = {{(TIME_W-CNT32_W){1'b0}}, gap_r};
      end
      S_MBUSY: begin
        alu_op = ALU_SATADD;
        alu_a  = {{(TIME_W-CNT32_W){1'b0}}, rd_busy};
        alu_b  = {{(TIME_W-CNT32_W){1'b0}}, gbusy_r};
      end
      S_EXP_AGE: begin
        alu_a = item_r.now_time;
        alu_b = rd_end;
      end
      S_SUM_TOT: begin
        alu_op = ALU_SATADD;
        alu_a  = {{(TIME_W-CNT32_W){1'b0}}, sum_tot_r};
        alu_b  = {{(TIME_W-CNT32_W){1'b0}}, rd_tot};
      end
      S_SUM_BUSY: begin
        alu_op = ALU_SATADD;
        alu_a  = {{(TIME_W-CNT32_W){1'b0}}, sum_busy_r};
        alu_b  = {{(TIME_W-CNT32_W){1'b0}}, rd_busy};
      end
      default: begin
        alu_op = ALU_SUBF;
      end
    endcase
  end

  wbt_alu u_alu (
    .op     (alu_op),
    .op_a   (alu_a),
    .op_b   (alu_b),
    .result (alu_res)
  );

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    last_nxt        = last_r;
    engine_busy_nxt = engine_busy_r;
    t_nxt           = t_r;
    gap_nxt         = gap_r;
    gbusy_nxt       = gbusy_r;
    sum_tot_nxt     = sum_tot_r;
    sum_busy_nxt    = sum_busy_r;
    sp_nxt          = sp_r;
    sn_nxt          = sn_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    wr_en           = 1'b0;
    wr_idx          = newest_idx;
    wr_end          = 1'b0;
    wr_tot          = 1'b0;
    wr_busy         = 1'b0;
    wr_end_val      = item_r.now_time;
    wr_tot_val      = alu_res.res[CNT32_W-1:0];
    wr_busy_val     = alu_res.res[CNT32_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_GAP;
        end
      end
      S_GAP: begin
        t_nxt     = alu_res.res;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        // gap above the window is clamped to it
        gap_nxt   = alu_res.lt ? window_r : t_r[CNT32_W-1:0];
        gbusy_nxt = engine_busy_r ? gap_nxt : '0;
        state_nxt = S_START;
      end
      S_START: begin
        t_nxt     = alu_res.res;
        state_nxt = (count_r == '0) ? S_OPEN : S_AGE;
      end
      S_AGE: begin
        t_nxt     = alu_res.res;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        state_nxt = alu_res.lt ? S_MTOT : S_OPEN;
      end
      S_MTOT: begin
        wr_en     = 1'b1;
        wr_end    = 1'b1;
        wr_tot    = 1'b1;
        state_nxt = S_MBUSY;
      end
      S_MBUSY: begin
        wr_en     = 1'b1;
        wr_busy   = 1'b1;
        state_nxt = S_EXP_AGE;
      end
      S_OPEN: begin
        // full store reuses the oldest slot
        wr_en       = 1'b1;
        wr_end      = 1'b1;
        wr_tot      = 1'b1;
        wr_busy     = 1'b1;
        wr_tot_val  = gap_r;
        wr_busy_val = gbusy_r;
        if (count_r == CNT_FULL) begin
          wr_idx   = head_r;
          head_nxt = inc_idx(head_r);
        end else begin
          wr_idx    = wrap_idx({1'b0, head_r} + (IDX_W+1)'(count_r));
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = S_EXP_AGE;
      end
      S_EXP_AGE: begin
        t_nxt     = alu_res.res;
        state_nxt = S_EXP_CMP;
      end
      S_EXP_CMP: begin
        sum_tot_nxt  = '0;
        sum_busy_nxt = '0;
        sn_nxt       = '0;
        if (alu_res.lt) begin
          head_nxt  = inc_idx(head_r);
          count_nxt = count_r - CNT_W'(1);
          state_nxt = (count_nxt == '0) ? S_DONE : S_EXP_AGE;
        end else begin
          sp_nxt    = head_r;
          state_nxt = S_SUM_TOT;
        end
      end
      S_SUM_TOT: begin
        sum_tot_nxt = alu_res.res[CNT32_W-1:0];
        state_nxt   = S_SUM_BUSY;
      end
      S_SUM_BUSY: begin
        sum_busy_nxt = alu_res.res[CNT32_W-1:0];
        sn_nxt       = sn_r + CNT_W'(1);
        sp_nxt       = inc_idx(sp_r);
        state_nxt    = (sn_nxt == count_r) ? S_DONE : S_SUM_TOT;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.window_total = sum_tot_r;
          out_data_nxt.window_busy  = sum_busy_r;
          last_nxt                  = item_r.now_time;
          if (!item_r.func) begin
            engine_busy_nxt = item_r.busy_flag;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      count_r       <= '0;
      last_r        <= '0;
      engine_busy_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      last_r        <= last_nxt;
      engine_busy_r <= engine_busy_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      bucket_r <= BUCKET_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW: window_r <= cfg_wdata;
        REG_BUCKET: bucket_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    t_r        <= t_nxt;
    gap_r      <= gap_nxt;
    gbusy_r    <= gbusy_nxt;
    sum_tot_r  <= sum_tot_nxt;
    sum_busy_r <= sum_busy_nxt;
    sp_r       <= sp_nxt;
    sn_r       <= sn_nxt;
    out_data_r <= out_data_nxt;
  end

  // Bucket store writes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_end) begin
        bend_r[wr_idx] <= wr_end_val;
      end
      if (wr_tot) begin
        btot_r[wr_idx] <= wr_tot_val;
      end
      if (wr_busy) begin
        bbusy_r[wr_idx] <= wr_busy_val;
      end
    end
  end

endmodule

### hw/rtl/wbt_alu.sv
// Shared arithmetic unit of the busy-time tracker.
// One 48-bit subtract (floored, with less-than flag) or a 32-bit saturating add.
// Depends on wbt_pkg.
module wbt_alu (
  input  logic                       op,
  input  logic [wbt_pkg::TIME_W-1:0] op_a,
  input  logic [wbt_pkg::TIME_W-1:0] op_b,
  output wbt_pkg::wbt_alu_res_t      result
);
  import wbt_pkg::*;

  logic [TIME_W:0]  diff;
  logic [CNT32_W:0] sum;

  // Single subtract yields both the floored difference and the compare
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign sum  = {1'b0, op_a[CNT32_W-1:0]} + {1'b0, op_b[CNT32_W-1:0]};

  always_comb begin
    result.lt = diff[TIME_W];
    if (op == ALU_SATADD) begin
      result.res = {{(TIME_W-CNT32_W){1'b0}},
                    (sum[CNT32_W] ? {CNT32_W{1'b1}} : sum[CNT32_W-1:0])};
    end else begin
      result.res = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
    end
  end

endmodule
